>>> hw/rtl/fast_pkg.sv
// Package for the fixed-depth shift table: operation codes, sequencer states
// and the packed widths of the stream items. No dependencies.

package fast_pkg;

  // Operation carried in the input item's tuser.
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_REVERSE = 2'd2,
    OP_SEARCH  = 2'd3
  } fast_op_t;

  // Sequencer states of the table core.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHUP,
    ST_SHDN,
    ST_PUT,
    ST_REV_A,
    ST_REV_B,
    ST_REV_C,
    ST_REV_D,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT
  } fast_state_t;

  localparam int POS_W       = 4;
  localparam int VALUE_W     = 32;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

endpackage

>>> hw/rtl/fixed_array_shift_table_core.sv
// Top level of the fixed-depth shift table: sequencer, valid bits and result register.
// Depends on fast_pkg and on fast_ram for the table storage.
//
// The block keeps a table of DEPTH words that reads as all zeros after reset.
// Each input item carries an operation in in_tuser: insert a word at a 1-based
// slot (later entries move toward the end and the last one drops off), delete
// the entry at a slot (later entries move toward the front and the last entry
// becomes zero), reverse the table, or search for a word. A slot of zero acts
// as slot 1 and a slot beyond DEPTH acts as slot DEPTH. Only a search gives
// results: one item per matching slot in ascending order with tlast on the final
// one, or a single not-found item (tuser 0, slot 0, tlast 1) when no entry
// matches. The table lives in a single-port-read RAM, so every operation walks
// the entries one RAM access at a time and the block takes one item at a time.
// Insert or delete moves the entries between the slot and the end of the table,
// reverse swaps the entries pair by pair from both ends, and search reads every
// entry before it emits its results, which wait while the result side stalls.
// No clearing pass is needed after reset: a valid bit per entry makes
// never-written entries read as zero. A finished result waits in an output
// register, so the next item is accepted while it is still pending.

module fixed_array_shift_table_core
  import fast_pkg::*;
#(
  parameter int DEPTH     = 8,
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input items.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [3:0] position, [35:4] value, [39:36] zero
  input  logic [OP_W-1:0]        in_tuser,   // [1:0] operation
  // Result items.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [3:0] match_position, [7:4] zero
  output logic                   out_tuser,  // [0] found
  output logic                   out_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST      = AW'(DEPTH - 1);
  localparam logic [AW-1:0] HALF_LAST = AW'(DEPTH / 2 - 1);
  localparam logic [7:0]    DEPTH_B   = 8'(DEPTH);

  // Sequencer and datapath registers.
  fast_state_t          st_r, st_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [WORD_BITS-1:0] tmp_r, tmp_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pend_addr_r, pend_addr_nxt;
  logic                 cmp_v_r, cmp_v_nxt;
  logic [AW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic [DEPTH-1:0]     match_r, match_nxt;
  logic [CW-1:0]        match_cnt_r, match_cnt_nxt;
  logic [CW-1:0]        emit_cnt_r, emit_cnt_nxt;
  logic [DEPTH-1:0]     valid_r;
  logic                 rd_valid_r;

  // Result register.
  logic                 out_valid_r;
  logic                 out_found_r, out_found_nxt;
  logic [POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_load;
  logic                 out_free;

  // RAM port signals.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] rd_eff;

  // Decoded input item.
  logic [7:0]           pos_b;
  logic [AW-1:0]        in_slot;
  logic [63:0]          word_wide;
  logic [WORD_BITS-1:0] in_word;
  fast_op_t             in_op;
  logic [7:0]           mpos_b;

  fast_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // An entry that was never written reads as zero.
  assign rd_eff = rd_valid_r ? ram_rdata : '0;

  // The position is clamped into the table; the value keeps its low WORD_BITS bits,
  // zero-extended when the word is wider than the field.
  assign in_op     = fast_op_t'(in_tuser);
  assign pos_b     = {4'b0, in_tdata[3:0]};
  assign word_wide = {32'b0, in_tdata[35:4]};
  assign in_word   = word_wide[WORD_BITS-1:0];
  assign in_slot   = (pos_b == 8'd0)    ? '0 :
                     (pos_b > DEPTH_B)  ? LAST :
                     AW'(pos_b - 8'd1);

  assign mpos_b   = 8'(idx_r) + 8'd1;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    word_nxt      = word_r;
    tmp_nxt       = tmp_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    cmp_v_nxt     = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    match_nxt     = match_r;
    match_cnt_nxt = match_cnt_r;
    emit_cnt_nxt  = emit_cnt_r;
    out_load      = 1'b0;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    // A pending shift write-back goes out whenever one is queued.
    ram_we        = pend_r;
    ram_waddr     = pend_addr_r;
    ram_wdata     = rd_eff;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;

    // Compare stage of the search sweep, in the cycle after the read.
    if (cmp_v_r && (rd_eff == word_r)) begin
      match_nxt[cmp_idx_r] = 1'b1;
      match_cnt_nxt        = match_cnt_r + CW'(1);
    end

    case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            OP_INSERT: begin
              slot_nxt = in_slot;
              word_nxt = in_word;
              if (in_slot == LAST) begin
                st_nxt = ST_PUT;
              end else begin
                idx_nxt = LAST - AW'(1);
                st_nxt  = ST_SHUP;
              end
            end
            OP_DELETE: begin
              // Delete always finishes by clearing the last entry.
              slot_nxt = LAST;
              word_nxt = '0;
              if (in_slot == LAST) begin
                st_nxt = ST_PUT;
              end else begin
                idx_nxt = in_slot + AW'(1);
                st_nxt  = ST_SHDN;
              end
            end
            OP_REVERSE: begin
              idx_nxt = '0;
              st_nxt  = ST_REV_A;
            end
            OP_SEARCH: begin
              word_nxt      = in_word;
              idx_nxt       = '0;
              match_nxt     = '0;
              match_cnt_nxt = '0;
              st_nxt        = ST_SCAN;
            end
            default: begin
              st_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SHUP: begin
        ram_re        = 1'b1;
        pend_nxt      = 1'b1;
        pend_addr_nxt = idx_r + AW'(1);
        if (idx_r == slot_r) begin
          st_nxt = ST_PUT;
        end else begin
          idx_nxt = idx_r - AW'(1);
        end
      end

      ST_SHDN: begin
        ram_re        = 1'b1;
        pend_nxt      = 1'b1;
        pend_addr_nxt = idx_r - AW'(1);
        if (idx_r == LAST) begin
          st_nxt = ST_PUT;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      ST_PUT: begin
        // Drain the last shift write first, then store the word.
        if (!pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = slot_r;
          ram_wdata = word_r;
          st_nxt    = ST_IDLE;
        end
      end

      ST_REV_A: begin
        ram_re = 1'b1;
        st_nxt = ST_REV_B;
      end

      ST_REV_B: begin
        ram_re    = 1'b1;
        ram_raddr = LAST - idx_r;
        tmp_nxt   = rd_eff;
        st_nxt    = ST_REV_C;
      end

      ST_REV_C: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = rd_eff;
        st_nxt    = ST_REV_D;
      end

      ST_REV_D: begin
        ram_we    = 1'b1;
        ram_waddr = LAST - idx_r;
        ram_wdata = tmp_r;
        if (idx_r == HALF_LAST) begin
          st_nxt = ST_IDLE;
        end else begin
          // The low entry of the next pair is read while the high one is written.
          idx_nxt   = idx_r + AW'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_r + AW'(1);
          st_nxt    = ST_REV_B;
        end
      end

      ST_SCAN: begin
        ram_re      = 1'b1;
        cmp_v_nxt   = 1'b1;
        cmp_idx_nxt = idx_r;
        if (idx_r == LAST) begin
          st_nxt = ST_SCAN_END;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      ST_SCAN_END: begin
        idx_nxt      = '0;
        emit_cnt_nxt = '0;
        st_nxt       = ST_EMIT;
      end

      ST_EMIT: begin
        if (match_cnt_r == '0) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_found_nxt = 1'b0;
            out_pos_nxt   = '0;
            out_last_nxt  = 1'b1;
            st_nxt        = ST_IDLE;
          end
        end else if (!match_r[idx_r]) begin
          idx_nxt = idx_r + AW'(1);
        end else if (out_free) begin
          out_load      = 1'b1;
          out_found_nxt = 1'b1;
          out_pos_nxt   = mpos_b[3:0];
          out_last_nxt  = ((emit_cnt_r + CW'(1)) == match_cnt_r);
          emit_cnt_nxt  = emit_cnt_r + CW'(1);
          if ((emit_cnt_r + CW'(1)) == match_cnt_r) begin
            st_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pend_r      <= 1'b0;
      cmp_v_r     <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      pend_r  <= pend_nxt;
      cmp_v_r <= cmp_v_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    slot_r      <= slot_nxt;
    word_r      <= word_nxt;
    tmp_r       <= tmp_nxt;
    pend_addr_r <= pend_addr_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    match_r     <= match_nxt;
    match_cnt_r <= match_cnt_nxt;
    emit_cnt_r  <= emit_cnt_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_last_r  <= out_last_nxt;
    if (ram_re) begin
      rd_valid_r <= valid_r[ram_raddr];
    end
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_pos_r};
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  // A read never targets the entry being written in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("table read and write hit the same entry");

  // While emitting matches, fewer results have gone out than were found.
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_EMIT) && (match_cnt_r != '0)) |-> (emit_cnt_r < match_cnt_r))
    else $error("search emitted more results than matches");

  // A not-found result is only produced by a search with no match.
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !out_found_nxt) |-> (match_cnt_r == '0))
    else $error("not-found result despite a match");

  // The final result of a search returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> (st_r == ST_IDLE))
    else $error("sequencer busy after final search result");

  // Nothing is left in flight when a new item can be taken.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> (!pend_r && !cmp_v_r))
    else $error("write-back or compare pending in idle");

endmodule

>>> hw/rtl/fast_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the table storage; no dependencies.

module fast_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
